@@ sv/gdk_pkg.sv @@
// ----------------------------------------------------------------------------
// gdk_pkg
// shared types, constants and tables of the gaussian derivative kernel core
// ----------------------------------------------------------------------------
package gdk_pkg;

  localparam int DIM_MAX  = 7;
  localparam int IDX_W    = 3;
  localparam int COORD_W  = 24;
  localparam int DIFF_W   = 25;
  localparam int THETA_W  = 24;
  localparam int R2_W     = 56;
  localparam int CM_W     = 49;
  localparam int RAM_W    = DIFF_W + 1;
  localparam int ENTRY_W  = 48;
  localparam int P_W      = 33;
  localparam int X_W      = 37;
  localparam int Y_W      = 38;
  localparam int PROD_W   = 96;
  localparam int RECIP_W  = 37;

  localparam logic [P_W-1:0]    ONE_Q32    = 33'h1_0000_0000;
  localparam logic [31:0]       LOG2E_FRAC = 32'h7154_7653;
  localparam logic [31:0]       LN2_Q32    = 32'hB172_17F8;
  localparam logic [75:0]       EXP_LIMIT  = 76'd24 << 48;
  localparam logic [3:0]        SERIES_TERMS = 4'd10;
  localparam logic [63:0]       POS_LIMIT  = (64'd1 << 47) - 64'd1;
  localparam logic [63:0]       NEG_LIMIT  = 64'd1 << 47;

  // register indexes on the apb port
  localparam logic [0:0] REG_THETA = 1'b0;
  localparam logic [0:0] REG_DIM   = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] n;
    logic [R2_W-1:0]  r2;
  } job_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [RAM_W-1:0] data;
  } ram_wr_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_THR,
    B_Y,
    B_T,
    B_HTP,
    B_HREC,
    B_HCOR,
    B_SCALE,
    B_RD,
    B_E1,
    B_E2,
    B_OUT
  } back_state_t;

  // floor(2^36 / k) for the series divisors
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] k);
    logic [RECIP_W-1:0] r;
    case (k)
      4'd1:    r = 37'd68719476736;
      4'd2:    r = 37'd34359738368;
      4'd3:    r = 37'd22906492245;
      4'd4:    r = 37'd17179869184;
      4'd5:    r = 37'd13743895347;
      4'd6:    r = 37'd11453246122;
      4'd7:    r = 37'd9817068105;
      4'd8:    r = 37'd8589934592;
      4'd9:    r = 37'd7635497415;
      4'd10:   r = 37'd6871947673;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/gdk_ram.sv @@
// ----------------------------------------------------------------------------
// gdk_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module gdk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ sv/gdk_mul.sv @@
// ----------------------------------------------------------------------------
// gdk_mul
// shared 64 x 64 multiplier, four 32 x 32 partial products, product mod 2^96
// ----------------------------------------------------------------------------
module gdk_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [63:0]                a,
  input  logic [63:0]                b,
  output logic                       done,
  output logic [gdk_pkg::PROD_W-1:0] prod
);

  logic        busy;
  logic [2:0]  cnt;
  logic [63:0] ra;
  logic [63:0] rb;
  logic [63:0] pp;
  logic [1:0]  sh;
  logic        ppv;
  logic [gdk_pkg::PROD_W-1:0] acc;
  logic [31:0] sa;
  logic [31:0] sb;
  logic [1:0]  sh_c;
  logic [gdk_pkg::PROD_W-1:0] pp_ext;

  always_comb begin
    case (cnt)
      3'd0:    begin sa = ra[31:0];  sb = rb[31:0];  sh_c = 2'd0; end
      3'd1:    begin sa = ra[63:32]; sb = rb[31:0];  sh_c = 2'd1; end
      3'd2:    begin sa = ra[31:0];  sb = rb[63:32]; sh_c = 2'd1; end
      3'd3:    begin sa = ra[63:32]; sb = rb[63:32]; sh_c = 2'd2; end
      default: begin sa = '0;        sb = '0;        sh_c = 2'd0; end
    endcase
  end

  always_comb begin
    case (sh)
      2'd0:    pp_ext = {32'b0, pp};
      2'd1:    pp_ext = {pp, 32'b0};
      2'd2:    pp_ext = {pp[31:0], 64'b0};
      default: pp_ext = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ppv  <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        ppv  <= 1'b0;
      end else if (busy) begin
        ppv <= (cnt < 3'd4);
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ra  <= a;
      rb  <= b;
      acc <= '0;
    end else if (busy) begin
      pp <= sa * sb;
      sh <= sh_c;
      if (ppv) begin
        acc <= acc + pp_ext;
      end
    end
  end

  assign prod = acc;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("multiplier done while still busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("multiplier done longer than one cycle");

endmodule

@@ sv/gdk_front.sv @@
// ----------------------------------------------------------------------------
// gdk_front
// takes coordinate beats, stores |d| and its sign per dimension, builds r2 jobs
// ----------------------------------------------------------------------------
module gdk_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic signed [gdk_pkg::COORD_W-1:0]   first_coord,
  input  logic signed [gdk_pkg::COORD_W-1:0]   second_coord,
  input  logic [gdk_pkg::IDX_W-1:0]            dimension_count,
  output gdk_pkg::ram_wr_t                     ram_wr,
  output logic                                 push,
  output gdk_pkg::job_t                        job,
  output logic                                 pending
);

  logic [gdk_pkg::IDX_W-1:0]  dims;
  logic [gdk_pkg::R2_W-1:0]   r2;
  logic                       a_valid;
  logic                       a_last;
  logic                       a_neg;
  logic [gdk_pkg::IDX_W-1:0]  a_idx;
  logic [gdk_pkg::DIFF_W-1:0] a_mag;

  logic signed [gdk_pkg::DIFF_W-1:0] diff;
  logic [gdk_pkg::DIFF_W-1:0] mag;
  logic [gdk_pkg::IDX_W-1:0]  idx;
  logic [gdk_pkg::IDX_W-1:0]  need;
  logic                       last_c;
  logic [49:0]                sq;
  logic [gdk_pkg::R2_W-1:0]   r2_next;

  always_comb begin
    diff = gdk_pkg::DIFF_W'(first_coord) - gdk_pkg::DIFF_W'(second_coord);
    mag  = diff[gdk_pkg::DIFF_W-1] ? gdk_pkg::DIFF_W'(-diff) : gdk_pkg::DIFF_W'(diff);
    // zero count means one, counts above the store depth clamp to it
    if (dimension_count == '0) begin
      need = gdk_pkg::IDX_W'(1);
    end else if (32'(dimension_count) > gdk_pkg::DIM_MAX) begin
      need = gdk_pkg::IDX_W'(gdk_pkg::DIM_MAX);
    end else begin
      need = dimension_count;
    end
    if (32'(dims) >= gdk_pkg::DIM_MAX) begin
      idx = gdk_pkg::IDX_W'(gdk_pkg::DIM_MAX - 1);
    end else begin
      idx = dims;
    end
    last_c  = ({1'b0, idx} + 4'd1) >= {1'b0, need};
    sq      = 50'(a_mag) * 50'(a_mag);
    r2_next = r2 + gdk_pkg::R2_W'(sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      dims    <= '0;
      r2      <= '0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        dims <= last_c ? '0 : idx + gdk_pkg::IDX_W'(1);
      end
      if (a_valid) begin
        r2 <= a_last ? '0 : r2_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_mag  <= mag;
      a_neg  <= diff[gdk_pkg::DIFF_W-1];
      a_idx  <= idx;
      a_last <= last_c;
    end
  end

  always_comb begin
    ram_wr.we   = a_valid;
    ram_wr.addr = a_idx;
    ram_wr.data = {a_neg, a_mag};
    push        = a_valid & a_last;
    job.n       = a_idx + gdk_pkg::IDX_W'(1);
    job.r2      = r2_next;
    pending     = a_valid & a_last;
  end

endmodule

@@ sv/gdk_fifo.sv @@
// ----------------------------------------------------------------------------
// gdk_fifo
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module gdk_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gdk_pkg::job_t job_in,
  input  logic          pop,
  output gdk_pkg::job_t job_out,
  output logic          empty
);

  gdk_pkg::job_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= job_in;
    end
  end

  assign job_out = slots[rptr];
  assign empty   = (count == '0);

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> count != 2'd0)
    else $error("job queue popped while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != 2'd2)
    else $error("job queue pushed while full");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("job queue count out of range");

endmodule

@@ sv/gdk_back.sv @@
// ----------------------------------------------------------------------------
// gdk_back
// sequencer: exp(-theta*r2) by series, then one matrix entry per pass
// ----------------------------------------------------------------------------
module gdk_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [gdk_pkg::THETA_W-1:0]         theta,
  input  logic                                job_empty,
  input  gdk_pkg::job_t                       job,
  output logic                                pop,
  output logic [gdk_pkg::IDX_W-1:0]           raddr_r,
  output logic [gdk_pkg::IDX_W-1:0]           raddr_c,
  input  logic [gdk_pkg::RAM_W-1:0]           rdata_r,
  input  logic [gdk_pkg::RAM_W-1:0]           rdata_c,
  output logic                                mul_start,
  output logic [63:0]                         mul_a,
  output logic [63:0]                         mul_b,
  input  logic                                mul_done,
  input  logic [gdk_pkg::PROD_W-1:0]          mul_prod,
  output logic                                active,
  output logic                                result_valid,
  output logic [gdk_pkg::IDX_W-1:0]           row_index,
  output logic [gdk_pkg::IDX_W-1:0]           col_index,
  output logic signed [gdk_pkg::ENTRY_W-1:0]  entry_value,
  output logic                                saturated,
  output logic                                last_entry
);

  gdk_pkg::back_state_t state;
  gdk_pkg::back_state_t state_next;

  logic                       issued;
  logic [gdk_pkg::IDX_W-1:0]  n_job;
  logic [gdk_pkg::R2_W-1:0]   r2;
  logic                       in_range;
  logic [gdk_pkg::P_W-1:0]    s;
  logic [gdk_pkg::X_W-1:0]    x;
  logic [5:0]                 nsh;
  logic [31:0]                yfrac;
  logic [31:0]                t;
  logic [gdk_pkg::P_W-1:0]    p;
  logic [3:0]                 k;
  logic [gdk_pkg::P_W-1:0]    v;
  logic [gdk_pkg::P_W-1:0]    qe;
  logic [gdk_pkg::IDX_W-1:0]  r;
  logic [gdk_pkg::IDX_W-1:0]  c;
  logic [63:0]                qv;
  logic [63:0]                m;
  logic                       neg_m;

  logic        k00;
  logic        kedge;
  logic        kdiag;
  logic        e_skip;
  logic        is_mul;
  logic        thr_ok;
  logic        last_c;
  logic [gdk_pkg::Y_W-1:0] y;
  logic [36:0] qk;
  logic [36:0] rem;
  logic [gdk_pkg::P_W-1:0] q_fix;
  logic [63:0] q4;
  logic [63:0] tt;
  logic [gdk_pkg::CM_W-1:0] cm_r;
  logic [gdk_pkg::CM_W-1:0] cm_c;
  logic [gdk_pkg::ENTRY_W-1:0] mc;
  logic        sat_c;

  always_comb begin
    k00    = (r == '0) && (c == '0);
    kedge  = (r == '0) != (c == '0);
    kdiag  = (r == c) && (r != '0);
    e_skip = k00 || !in_range;
    last_c = (r == n_job) && (c == n_job);
    thr_ok = (theta == '0) || (mul_prod[75:0] <= gdk_pkg::EXP_LIMIT);
    // theta*|d| from the stored magnitude, theta as it stands for this matrix
    cm_r   = gdk_pkg::CM_W'(theta) * gdk_pkg::CM_W'(rdata_r[gdk_pkg::DIFF_W-1:0]);
    cm_c   = gdk_pkg::CM_W'(theta) * gdk_pkg::CM_W'(rdata_c[gdk_pkg::DIFF_W-1:0]);
    y      = gdk_pkg::Y_W'(x) + gdk_pkg::Y_W'(gdk_pkg::Y_W'(x[36:32]) *
             gdk_pkg::Y_W'(gdk_pkg::LOG2E_FRAC)) + gdk_pkg::Y_W'(mul_prod[63:32]);
    qk     = 37'(qe) * 37'(k);
    rem    = 37'(v) - qk;
    q_fix  = (rem >= 37'(k)) ? qe + gdk_pkg::P_W'(1) : qe;
    q4     = {mul_prod[93:32], 2'b00};
    tt     = 64'(theta) << 17;
    // clip to the 48-bit signed range
    if (!neg_m && m > gdk_pkg::POS_LIMIT) begin
      mc = gdk_pkg::POS_LIMIT[gdk_pkg::ENTRY_W-1:0];
      sat_c = 1'b1;
    end else if (neg_m && m > gdk_pkg::NEG_LIMIT) begin
      mc = gdk_pkg::NEG_LIMIT[gdk_pkg::ENTRY_W-1:0];
      sat_c = 1'b1;
    end else begin
      mc = m[gdk_pkg::ENTRY_W-1:0];
      sat_c = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gdk_pkg::B_IDLE:  if (!job_empty) state_next = gdk_pkg::B_THR;
      gdk_pkg::B_THR:   if (mul_done) begin
        state_next = (theta == '0 || !thr_ok) ? gdk_pkg::B_RD : gdk_pkg::B_Y;
      end
      gdk_pkg::B_Y:     if (mul_done) state_next = gdk_pkg::B_T;
      gdk_pkg::B_T:     if (mul_done) state_next = gdk_pkg::B_HTP;
      gdk_pkg::B_HTP:   if (mul_done) state_next = gdk_pkg::B_HREC;
      gdk_pkg::B_HREC:  if (mul_done) state_next = gdk_pkg::B_HCOR;
      gdk_pkg::B_HCOR:  state_next = (k == 4'd1) ? gdk_pkg::B_SCALE : gdk_pkg::B_HTP;
      gdk_pkg::B_SCALE: state_next = gdk_pkg::B_RD;
      gdk_pkg::B_RD:    state_next = gdk_pkg::B_E1;
      gdk_pkg::B_E1: begin
        if (e_skip) begin
          state_next = gdk_pkg::B_OUT;
        end else if (mul_done) begin
          state_next = kedge ? gdk_pkg::B_OUT : gdk_pkg::B_E2;
        end
      end
      gdk_pkg::B_E2:    if (mul_done) state_next = gdk_pkg::B_OUT;
      gdk_pkg::B_OUT:   state_next = last_c ? gdk_pkg::B_IDLE : gdk_pkg::B_RD;
      default:          state_next = gdk_pkg::B_IDLE;
    endcase
  end

  // outputs to the queue, ram and multiplier
  always_comb begin
    pop     = (state == gdk_pkg::B_IDLE) && !job_empty;
    raddr_r = (r == '0) ? '0 : r - gdk_pkg::IDX_W'(1);
    raddr_c = (c == '0) ? '0 : c - gdk_pkg::IDX_W'(1);
    active  = (state != gdk_pkg::B_IDLE);
    mul_a   = '0;
    mul_b   = '0;
    is_mul  = 1'b1;
    case (state)
      gdk_pkg::B_THR:  begin mul_a = 64'(r2);    mul_b = 64'(theta); end
      gdk_pkg::B_Y:    begin mul_a = 64'(x[31:0]); mul_b = 64'(gdk_pkg::LOG2E_FRAC); end
      gdk_pkg::B_T:    begin mul_a = 64'(yfrac); mul_b = 64'(gdk_pkg::LN2_Q32); end
      gdk_pkg::B_HTP:  begin mul_a = 64'(t);     mul_b = 64'(p); end
      gdk_pkg::B_HREC: begin mul_a = 64'(v);     mul_b = 64'(gdk_pkg::recip(k)); end
      gdk_pkg::B_E1: begin
        if (kedge) begin
          mul_a = (r == '0) ? {14'b0, cm_c, 1'b0} : {14'b0, cm_r, 1'b0};
          mul_b = 64'(s);
        end else begin
          mul_a = 64'(cm_r);
          mul_b = 64'(cm_c);
        end
        is_mul = !e_skip;
      end
      gdk_pkg::B_E2:   begin mul_a = qv; mul_b = 64'(s); end
      default:         is_mul = 1'b0;
    endcase
    mul_start = is_mul && !issued;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gdk_pkg::B_IDLE;
      issued       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == gdk_pkg::B_OUT);
      if (mul_start) begin
        issued <= 1'b1;
      end else if (mul_done) begin
        issued <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      gdk_pkg::B_IDLE: begin
        n_job <= job.n;
        r2    <= job.r2;
        r     <= '0;
        c     <= '0;
      end
      gdk_pkg::B_THR: if (mul_done) begin
        in_range <= thr_ok;
        s        <= (theta == '0) ? gdk_pkg::ONE_Q32 : '0;
        x        <= mul_prod[52:16];
      end
      gdk_pkg::B_Y: if (mul_done) begin
        nsh   <= y[37:32];
        yfrac <= y[31:0];
      end
      gdk_pkg::B_T: if (mul_done) begin
        t <= mul_prod[63:32];
        p <= gdk_pkg::ONE_Q32;
        k <= gdk_pkg::SERIES_TERMS;
      end
      gdk_pkg::B_HTP:  if (mul_done) v <= mul_prod[64:32];
      gdk_pkg::B_HREC: if (mul_done) qe <= mul_prod[68:36];
      gdk_pkg::B_HCOR: begin
        p <= gdk_pkg::ONE_Q32 - q_fix;
        k <= k - 4'd1;
      end
      gdk_pkg::B_SCALE: s <= p >> nsh;
      gdk_pkg::B_E1: begin
        if (e_skip) begin
          m     <= (k00 && in_range) ? 64'(s) : '0;
          neg_m <= 1'b0;
        end else if (mul_done) begin
          if (kedge) begin
            m     <= mul_prod[95:32];
            // top row follows the sign of d, left column the opposite
            neg_m <= (r == '0) ? rdata_c[gdk_pkg::DIFF_W] : !rdata_r[gdk_pkg::DIFF_W];
          end else if (kdiag) begin
            qv    <= (q4 > tt) ? q4 - tt : tt - q4;
            neg_m <= (q4 > tt);
          end else begin
            qv    <= q4;
            neg_m <= (rdata_r[gdk_pkg::DIFF_W] == rdata_c[gdk_pkg::DIFF_W]);
          end
        end
      end
      gdk_pkg::B_E2: if (mul_done) m <= mul_prod[95:32];
      gdk_pkg::B_OUT: begin
        row_index   <= r;
        col_index   <= c;
        entry_value <= neg_m ? (~mc + gdk_pkg::ENTRY_W'(1)) : mc;
        saturated   <= sat_c;
        last_entry  <= last_c;
        if (c == n_job) begin
          c <= '0;
          r <= r + gdk_pkg::IDX_W'(1);
        end else begin
          c <= c + gdk_pkg::IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  a_last_diag: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_entry |-> row_index == col_index)
    else $error("last entry off the diagonal");
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == gdk_pkg::B_OUT)
    else $error("result strobe without an output pass");
  a_series_k: assert property (@(posedge clk) disable iff (rst)
    state == gdk_pkg::B_HCOR |-> k != 4'd0)
    else $error("series step with zero divisor");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == gdk_pkg::B_THR)
    else $error("job popped without starting");

endmodule

@@ sv/gaussian_derivative_kernel_matrix_core.sv @@
// ----------------------------------------------------------------------------
// gaussian_derivative_kernel_matrix_core
// gaussian kernel value and gradient covariance matrix, fixed point
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// coords    in         start & !busy                first_coord, second_coord
// entries   out        result_valid, one cycle      row_index, col_index,
//                                                   entry_value, saturated,
//                                                   last_entry
// apb       in/out     psel & penable & pready      paddr, pwdata, prdata
//
// a coordinate beat can be taken every cycle while a point fills up
// once the last beat of a point is in, busy stays high until its matrix is
// out: first the exponential (23 passes of the shared multiplier plus ten
// series corrections), then (n+1)^2 entries: the corner entry takes no
// multiplier pass, each other entry of the first row and column one pass
// and each inner entry two; a zero theta skips the series, out of range
// points skip it and the multiplier passes of every entry
// synchronous reset clears the control state; the difference ram is not
// cleared, only entries written for the current point are ever read
// the receiver cannot stall, so each entry beat stands for one cycle only
// ----------------------------------------------------------------------------
module gaussian_derivative_kernel_matrix_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [gdk_pkg::COORD_W-1:0]  first_coord,
  input  logic signed [gdk_pkg::COORD_W-1:0]  second_coord,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output logic                                result_valid,
  output logic [gdk_pkg::IDX_W-1:0]           row_index,
  output logic [gdk_pkg::IDX_W-1:0]           col_index,
  output logic signed [gdk_pkg::ENTRY_W-1:0]  entry_value,
  output logic                                saturated,
  output logic                                last_entry
);

  // configuration registers
  logic [gdk_pkg::THETA_W-1:0] theta;
  logic [gdk_pkg::IDX_W-1:0]   dimension_count;

  logic             accept;
  logic             cfg_wr;
  gdk_pkg::ram_wr_t ram_wr;
  logic             push;
  logic             pop;
  gdk_pkg::job_t    job_in;
  gdk_pkg::job_t    job_out;
  logic             job_empty;
  logic             pending;
  logic             back_active;
  logic [gdk_pkg::IDX_W-1:0] raddr_r;
  logic [gdk_pkg::IDX_W-1:0] raddr_c;
  logic [gdk_pkg::RAM_W-1:0] rdata_r;
  logic [gdk_pkg::RAM_W-1:0] rdata_c;
  logic             mul_start;
  logic [63:0]      mul_a;
  logic [63:0]      mul_b;
  logic             mul_done;
  logic [gdk_pkg::PROD_W-1:0] mul_prod;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  // a new point may not overwrite the ram while a matrix is still going out
  assign busy   = pending | !job_empty | back_active;
  assign accept = start & !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      theta           <= gdk_pkg::THETA_W'(65536);
      dimension_count <= gdk_pkg::IDX_W'(3);
    end else if (cfg_wr) begin
      case (paddr[2])
        gdk_pkg::REG_THETA: theta           <= pwdata[gdk_pkg::THETA_W-1:0];
        gdk_pkg::REG_DIM:   dimension_count <= pwdata[gdk_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gdk_pkg::REG_THETA: prdata = 32'(theta);
      gdk_pkg::REG_DIM:   prdata = 32'(dimension_count);
      default:            prdata = '0;
    endcase
  end

  // front: difference, |d| and sign into the ram, r2 accumulation
  gdk_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .first_coord     (first_coord),
    .second_coord    (second_coord),
    .dimension_count (dimension_count),
    .ram_wr          (ram_wr),
    .push            (push),
    .job             (job_in),
    .pending         (pending)
  );

  // |d| with the sign of d, one row per dimension
  gdk_ram #(
    .WIDTH (gdk_pkg::RAM_W),
    .DEPTH (gdk_pkg::DIM_MAX)
  ) u_ram (
    .clk     (clk),
    .we      (ram_wr.we),
    .waddr   (ram_wr.addr),
    .wdata   (ram_wr.data),
    .raddr_a (raddr_r),
    .raddr_b (raddr_c),
    .rdata_a (rdata_r),
    .rdata_b (rdata_c)
  );

  // finished points waiting for the back end
  gdk_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .job_in  (job_in),
    .pop     (pop),
    .job_out (job_out),
    .empty   (job_empty)
  );

  gdk_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // back: exponential, then the matrix row by row
  gdk_back u_back (
    .clk          (clk),
    .rst          (rst),
    .theta        (theta),
    .job_empty    (job_empty),
    .job          (job_out),
    .pop          (pop),
    .raddr_r      (raddr_r),
    .raddr_c      (raddr_c),
    .rdata_r      (rdata_r),
    .rdata_c      (rdata_c),
    .mul_start    (mul_start),
    .mul_a        (mul_a),
    .mul_b        (mul_b),
    .mul_done     (mul_done),
    .mul_prod     (mul_prod),
    .active       (back_active),
    .result_valid (result_valid),
    .row_index    (row_index),
    .col_index    (col_index),
    .entry_value  (entry_value),
    .saturated    (saturated),
    .last_entry   (last_entry)
  );

endmodule
